// ===== hdl/ffra_pkg.sv =====
// Shared types, sizes and codes for the first-fit region allocator.
// Used by ffra_ctrl, ffra_dpath and first_fit_region_allocator_core; no dependencies.
package ffra_pkg;

  // Table and page geometry
  localparam int TABLE_ENTRIES = 256;
  localparam int PAGE_BYTES    = 4096;
  localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // Field widths
  localparam int ADDR_W   = 32;
  localparam int FFC_W    = 21;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 8;

  // Page count of a full-range size, and widths for the frame arithmetic
  localparam int PG_W  = ADDR_W + 1 - PAGE_SHIFT;
  localparam int SUM_W = ((PG_W > FFC_W) ? PG_W : FFC_W) + 1;
  localparam int CAP_W = FFC_W + PAGE_SHIFT;
  localparam int CMP_W = ((CAP_W > ADDR_W) ? CAP_W : ADDR_W) + 1;

  localparam logic [FFC_W-1:0]  FFC_MAX   = {FFC_W{1'b1}};
  localparam logic [ADDR_W:0]   PAGE_LOW  = (ADDR_W+1)'(PAGE_BYTES - 1);
  localparam logic [ADDR_W:0]   PAGE_MASK = ~PAGE_LOW;
  localparam logic [ADDR_W-1:0] PAGE_SIZE = ADDR_W'(PAGE_BYTES);

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OOM      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_START  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_FRAMES = 8'd1;

  // One region table entry
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    logic              used;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                load_req;
    logic                prep;
    logic                scan_step;
    logic                hit_pages;
    logic                hit_commit;
    logic                app_pages;
    logic                app_commit;
    logic                load_out;
    logic [STATUS_W-1:0] status;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_free;
    logic req_null;
    logic req_oom;
    logic addr_ovf;
    logic table_full;
    logic rd_match;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

  // Pages covered by a byte size, rounded up
  function automatic logic [PG_W-1:0] pages_of(input logic [ADDR_W-1:0] size);
    logic [ADDR_W:0] sum;
    sum = {1'b0, size} + PAGE_LOW;
    return sum[ADDR_W:PAGE_SHIFT];
  endfunction

endpackage

// ===== hdl/first_fit_region_allocator_core.sv =====
// First-fit region allocator: input/output stream channels, configuration
// write channel. Builds on ffra_pkg, ffra_ctrl and ffra_dpath.
//
// Usage. Each transaction on the s_ channel is one request: s_tuser is the
// command (0 allocate, 1 free), s_tdata carries the request size and the
// address to free. Each request yields exactly one result transaction on the
// m_ channel with the region base, a status code and the free frame count.
// The cfg_ channel writes heap_start (index 0, also loads the bump pointer)
// or free_frames_at_start (index 1, also loads the frame count); other
// indexes are ignored. cfg_ready is high outside reset; write only when idle.
// The next request is taken only after the result of the last one has been
// loaded into the output register, so one request is worked on at a time.
// Reset empties the table, clears the bump pointer and frame count and
// drops m_tvalid and s_tready. The table memory itself is not cleared: only
// entries below the fill count are ever read. If the receiver stalls, the
// result waits in the output register; the next request is still accepted
// and worked on, and only its result waits for the register to empty.
module first_fit_region_allocator_core
  import ffra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,   // [31:0] request_size, [63:32] free_address
  input  logic                 s_tuser,   // [0] cmd
  // result channel
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [55:0]          m_tdata,   // [31:0] region_base, [34:32] status,
                                          // [55:35] frames_free
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  ctl_cmd_t            ctl_cmd;
  dp_sts_t             dp_sts;
  logic [ADDR_W-1:0]   out_base;
  logic [STATUS_W-1:0] out_status;
  logic [FFC_W-1:0]    out_frames;

  assign cfg_ready = !rst;

  ffra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (dp_sts),
    .cmd      (ctl_cmd)
  );

  ffra_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (ctl_cmd),
    .sts        (dp_sts),
    .req_free   (s_tuser),
    .req_size   (s_tdata[31:0]),
    .req_addr   (s_tdata[63:32]),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_base   (out_base),
    .out_status (out_status),
    .out_frames (out_frames)
  );

  assign m_tdata = {out_frames, out_status, out_base};

  // A result is only loaded into a free output register
  assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.load_out |-> dp_sts.out_free)
    else $error("result loaded over an unaccepted result");

  // Failed requests never report a base
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_status != ST_OK)) |-> (out_base == '0))
    else $error("non-zero base on a failed request");

  // Status codes stay within the defined set
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_status <= ST_NOTFOUND))
    else $error("undefined status code");

  // Appends only happen while the table has room
  assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.app_commit |-> !dp_sts.table_full)
    else $error("append into a full table");

endmodule

// ===== hdl/ffra_dpath.sv =====
// Datapath of the region allocator: request registers, region table memory,
// scan counter, frame count and result register. Depends on ffra_pkg.
module ffra_dpath
  import ffra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_cmd_t             cmd,
  output dp_sts_t              sts,
  input  logic                 req_free,
  input  logic [ADDR_W-1:0]    req_size,
  input  logic [ADDR_W-1:0]    req_addr,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [ADDR_W-1:0]    out_base,
  output logic [STATUS_W-1:0]  out_status,
  output logic [FFC_W-1:0]     out_frames
);

  // Region table
  entry_t mem [TABLE_ENTRIES];

  // Request registers
  logic              is_free;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] sz;
  logic              req_null;
  logic              oom;
  logic [ADDR_W:0]   start;
  logic              ovf;

  // Allocator state
  logic [ADDR_W-1:0] bump;
  logic [FFC_W-1:0]  ffc;
  logic [CNT_W-1:0]  count;

  // Scan
  logic [CNT_W-1:0]  idx;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_vld;
  entry_t            rd_entry;
  logic              rd_match;
  logic              issue;

  logic [PG_W-1:0]   pages;
  logic [ADDR_W-1:0] res_base;

  // Frame arithmetic
  logic [SUM_W-1:0]  give_sum;
  logic [FFC_W-1:0]  ffc_give;
  logic [FFC_W-1:0]  ffc_take;
  logic [ADDR_W+1:0] end_sum;
  logic [CMP_W-1:0]  cap;

  // Memory write port
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  // Compare of the entry just read against the request
  always_comb begin
    if (is_free) begin
      rd_match = rd_vld && rd_entry.used && (rd_entry.base == addr);
    end else begin
      rd_match = rd_vld && !rd_entry.used && (rd_entry.size >= sz);
    end
    issue = cmd.scan_step && (idx < count) && !rd_match;
  end

  always_comb begin
    give_sum = SUM_W'(ffc) + SUM_W'(pages);
    ffc_give = (give_sum > SUM_W'(FFC_MAX)) ? FFC_MAX : FFC_W'(give_sum);
    ffc_take = (SUM_W'(pages) >= SUM_W'(ffc)) ? '0 : FFC_W'(SUM_W'(ffc) - SUM_W'(pages));
    end_sum  = {1'b0, start} + {2'b00, sz};
    cap      = CMP_W'(ffc) << PAGE_SHIFT;
  end

  // Write port: set or clear the in-use bit of a hit, or append
  always_comb begin
    wr_en   = cmd.hit_commit || cmd.app_commit;
    wr_addr = rd_addr;
    wr_data = '{base: rd_entry.base, size: rd_entry.size, used: !is_free};
    if (cmd.app_commit) begin
      wr_addr = count[IDX_W-1:0];
      wr_data = '{base: start[ADDR_W-1:0], size: sz, used: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_entry <= mem[idx[IDX_W-1:0]];
    end
  end

  // Request capture and derived checks
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      is_free  <= req_free;
      addr     <= req_addr;
      sz       <= (req_size < PAGE_SIZE) ? PAGE_SIZE : req_size;
      req_null <= req_free ? (req_addr == '0) : (req_size == '0);
    end
    if (cmd.prep) begin
      oom <= CMP_W'(sz) > cap;
    end
    // Bump pointer rounded up to a page, and end-of-region overflow
    start <= ({1'b0, bump} + PAGE_LOW) & PAGE_MASK;
    ovf   <= |end_sum[ADDR_W+1:ADDR_W];
    if (cmd.hit_pages) begin
      pages <= pages_of(rd_entry.size);
    end else if (cmd.app_pages) begin
      pages <= pages_of(sz);
    end
    if (cmd.prep) begin
      res_base <= '0;
    end else if (cmd.hit_commit) begin
      res_base <= rd_entry.base;
    end else if (cmd.app_commit) begin
      res_base <= start[ADDR_W-1:0];
    end
    if (issue) begin
      rd_addr <= idx[IDX_W-1:0];
    end
    if (cmd.load_out) begin
      out_base   <= res_base;
      out_status <= cmd.status;
      out_frames <= ffc;
    end
  end

  // Control state: table fill, pointers, scan and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      bump      <= '0;
      ffc       <= '0;
      count     <= '0;
      idx       <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.prep) begin
        idx    <= '0;
        rd_vld <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_vld <= issue;
        if (issue) begin
          idx <= idx + 1'b1;
        end
      end
      if (cmd.hit_commit) begin
        ffc <= is_free ? ffc_give : ffc_take;
      end else if (cmd.app_commit) begin
        ffc   <= ffc_take;
        count <= count + 1'b1;
        bump  <= end_sum[ADDR_W-1:0];
      end else if (cfg_valid && (cfg_index == REG_HEAP_START)) begin
        bump <= cfg_data;
      end else if (cfg_valid && (cfg_index == REG_FREE_FRAMES)) begin
        ffc <= cfg_data[FFC_W-1:0];
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Status to the controller
  always_comb begin
    sts.is_free    = is_free;
    sts.req_null   = req_null;
    sts.req_oom    = oom;
    sts.addr_ovf   = ovf;
    sts.table_full = (count == CNT_W'(TABLE_ENTRIES));
    sts.rd_match   = rd_match;
    sts.scan_done  = !rd_vld && (idx == count);
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

// ===== hdl/ffra_ctrl.sv =====
// Sequencer of the region allocator: steps one request through check,
// table scan, commit and result hand-off. Depends on ffra_pkg.
module ffra_ctrl
  import ffra_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PREP    = 4'd1;
  localparam logic [3:0] S_DECIDE  = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_HIT     = 4'd4;
  localparam logic [3:0] S_HCOMMIT = 4'd5;
  localparam logic [3:0] S_APPEND  = 4'd6;
  localparam logic [3:0] S_ACOMMIT = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [STATUS_W-1:0] status;
  logic [STATUS_W-1:0] status_next;

  // Next state and commands
  always_comb begin
    state_next  = state;
    status_next = status;
    cmd         = '0;
    cmd.status  = status;
    in_ready    = 1'b0;
    unique case (state)
      // No transaction is taken while reset is held
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load_req = 1'b1;
          state_next   = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.req_null) begin
          status_next = ST_NULL;
          state_next  = S_DONE;
        end else if (!sts.is_free && sts.req_oom) begin
          status_next = ST_OOM;
          state_next  = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      // One table entry per cycle until a match or the last filled entry
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.rd_match) begin
          state_next = S_HIT;
        end else if (sts.scan_done) begin
          if (sts.is_free) begin
            status_next = ST_NOTFOUND;
            state_next  = S_DONE;
          end else if (sts.table_full) begin
            status_next = ST_FULL;
            state_next  = S_DONE;
          end else if (sts.addr_ovf) begin
            status_next = ST_OOM;
            state_next  = S_DONE;
          end else begin
            state_next = S_APPEND;
          end
        end
      end
      S_HIT: begin
        cmd.hit_pages = 1'b1;
        state_next    = S_HCOMMIT;
      end
      S_HCOMMIT: begin
        cmd.hit_commit = 1'b1;
        status_next    = ST_OK;
        state_next     = S_DONE;
      end
      S_APPEND: begin
        cmd.app_pages = 1'b1;
        state_next    = S_ACOMMIT;
      end
      S_ACOMMIT: begin
        cmd.app_commit = 1'b1;
        status_next    = ST_OK;
        state_next     = S_DONE;
      end
      // Hand the result over once the output register is free
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      status <= ST_OK;
    end else begin
      state  <= state_next;
      status <= status_next;
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for first_fit_region_allocator_core: directed and random requests,
// with a region table predictor kept in step with every accepted transaction.
// Depends on ffra_pkg and the core RTL only.
module testbench;
  import ffra_pkg::*;

  // Request kinds carried on s_tuser
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Register indexes outside the map, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP  = 8'hFF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_NEXT = 8'h02;

  localparam logic [31:0] FRAMES_ALL  = 32'h0010_0000;
  localparam int          RUN_LIMIT   = 3_000_000;
  localparam int          LONG_HOLD   = 2500;
  localparam int          DRAIN_WAIT  = 300;

  typedef struct packed {
    logic [ADDR_W-1:0]   base;
    logic [STATUS_W-1:0] status;
    logic [FFC_W-1:0]    frames;
  } region_outcome_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [63:0]          s_tdata;   // [31:0] request_size, [63:32] free_address
  logic                 s_tuser;   // [0] cmd
  logic                 m_tvalid;
  logic                 m_tready;
  logic [55:0]          m_tdata;   // [31:0] region_base, [34:32] status, [55:35] frames_free
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  // Predicted region table and counters
  logic [ADDR_W-1:0] ent_base [TABLE_ENTRIES];
  logic [ADDR_W-1:0] ent_size [TABLE_ENTRIES];
  logic              ent_used [TABLE_ENTRIES];
  int                ent_fill;
  logic [ADDR_W-1:0] bump_addr;
  logic [FFC_W-1:0]  frames_left;

  region_outcome_t outcomes_due[$];
  region_outcome_t outcome_now;

  logic idle_on;
  int   hold_cycles;
  int   stall_left;
  int   mismatches;
  int   cycle_count;

  first_fit_region_allocator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock, period 20
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Pages covered by a byte count, rounded up
  function automatic logic [31:0] page_count(input logic [31:0] bytes);
    logic [63:0] p;
    p = (64'(bytes) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
    return p[31:0];
  endfunction

  // Frames taken, clamped at zero
  function automatic void take_frames(input logic [31:0] pages);
    if (pages >= 32'(frames_left)) frames_left = '0;
    else frames_left = frames_left - pages[FFC_W-1:0];
  endfunction

  // Applies one request to the predicted table and returns its result
  function automatic region_outcome_t region_table_apply(input logic cmd,
                                                         input logic [31:0] size,
                                                         input logic [31:0] addr);
    region_outcome_t res;
    logic [31:0]     need;
    logic [31:0]     sum;
    logic [63:0]     start;
    int              hit;
    res.base   = '0;
    res.status = ST_OK;
    hit        = -1;
    if (cmd == CMD_FREE) begin
      if (addr == '0) begin
        res.status = ST_NULL;
      end else begin
        for (int i = 0; i < ent_fill; i++)
          if (hit < 0 && ent_used[i] && ent_base[i] == addr) hit = i;
        if (hit < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          ent_used[hit] = 1'b0;
          sum = 32'(frames_left) + page_count(ent_size[hit]);
          frames_left = (sum > 32'(FFC_MAX)) ? FFC_MAX : sum[FFC_W-1:0];
          res.base = addr;
        end
      end
    end else if (size == '0) begin
      res.status = ST_NULL;
    end else begin
      need = (size < 32'(PAGE_BYTES)) ? 32'(PAGE_BYTES) : size;
      if (64'(need) > 64'(frames_left) * 64'(PAGE_BYTES)) begin
        res.status = ST_OOM;
      end else begin
        // first fit over released entries
        for (int i = 0; i < ent_fill; i++)
          if (hit < 0 && !ent_used[i] && ent_size[i] >= need) hit = i;
        if (hit >= 0) begin
          ent_used[hit] = 1'b1;
          take_frames(page_count(ent_size[hit]));
          res.base = ent_base[hit];
        end else if (ent_fill >= TABLE_ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          start = ((64'(bump_addr) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES))
                  * 64'(PAGE_BYTES);
          if (start + 64'(need) > 64'hFFFF_FFFF) begin
            res.status = ST_OOM;
          end else begin
            ent_base[ent_fill] = start[31:0];
            ent_size[ent_fill] = need;
            ent_used[ent_fill] = 1'b1;
            ent_fill  = ent_fill + 1;
            bump_addr = start[31:0] + need;
            take_frames(page_count(need));
            res.base = start[31:0];
          end
        end
      end
    end
    res.frames = frames_left;
    return res;
  endfunction

  // Offers one request and records its predicted result on acceptance
  task automatic send_request(input logic cmd, input logic [31:0] size,
                              input logic [31:0] addr);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = {addr, size};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    outcomes_due.push_back(region_table_apply(cmd, size, addr));
    @(negedge clk);
  endtask

  // Stops offering and waits until every result has come back
  task automatic settle();
    s_tvalid = 1'b0;
    while (outcomes_due.size() != 0) @(negedge clk);
  endtask

  // One register write transaction; only called while the core is idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_HEAP_START) begin
      bump_addr = value;
    end else if (idx == REG_FREE_FRAMES) begin
      frames_left = value[FFC_W-1:0];
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic begin_phase(input logic [31:0] heap, input logic [31:0] frames);
    settle();
    write_register(REG_HEAP_START, heap);
    write_register(REG_FREE_FRAMES, frames);
  endtask

  // Random traffic: mostly allocations and frees of live regions, some noise
  task automatic run_random_phase(input int n_items, input int alloc_pct);
    int          r;
    int          pick;
    logic [31:0] sz;
    logic [31:0] live[$];
    logic [31:0] gone[$];
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      live.delete();
      gone.delete();
      for (int i = 0; i < ent_fill; i++)
        if (ent_used[i]) live.push_back(ent_base[i]);
        else gone.push_back(ent_base[i]);
      if (r < 10) begin
        // noise: null requests, stray or stale addresses
        pick = $urandom_range(0, 3);
        if (pick == 0) send_request(CMD_ALLOC, '0, $urandom);
        else if (pick == 1) send_request(CMD_FREE, $urandom, '0);
        else if (pick == 2 || gone.size() == 0) send_request(CMD_FREE, $urandom, $urandom);
        else send_request(CMD_FREE, $urandom, gone[$urandom_range(0, gone.size() - 1)]);
      end else if (r < 10 + alloc_pct) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) sz = $urandom_range(1, 12288);
        else if (pick < 65) sz = 32'($urandom_range(1, 16)) << 12;
        else if (pick < 80) sz = $urandom_range(4095, 4097);
        else if (pick < 94) sz = $urandom_range(1, 32'h00FF_FFFF);
        else sz = $urandom;
        send_request(CMD_ALLOC, sz, $urandom);
      end else if (live.size() != 0) begin
        send_request(CMD_FREE, $urandom, live[$urandom_range(0, live.size() - 1)]);
      end else begin
        send_request(CMD_FREE, $urandom, $urandom);
      end
    end
  endtask

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    m_tready   = 1'b1;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready    = 1'b0;
        hold_cycles = hold_cycles - 1;
      end else if (stall_left > 0) begin
        m_tready   = 1'b0;
        stall_left = stall_left - 1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        m_tready   = 1'b0;
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (outcomes_due.size() == 0) begin
        $error("result with none pending: %h", m_tdata);
        mismatches = mismatches + 1;
      end else begin
        outcome_now = outcomes_due.pop_front();
        if (m_tdata[31:0] !== outcome_now.base) begin
          $error("region_base: expected %h, got %h", outcome_now.base, m_tdata[31:0]);
          mismatches = mismatches + 1;
        end
        if (m_tdata[34:32] !== outcome_now.status) begin
          $error("status: expected %0d, got %0d", outcome_now.status, m_tdata[34:32]);
          mismatches = mismatches + 1;
        end
        if (m_tdata[55:35] !== outcome_now.frames) begin
          $error("frames_free: expected %0d, got %0d", outcome_now.frames, m_tdata[55:35]);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  task automatic test_register_writes();
    write_register(REG_HEAP_START, 32'h0000_1234);
    write_register(REG_FREE_FRAMES, 32'd8);
    write_register(REG_UNUSED_TOP, $urandom);
    write_register(REG_UNUSED_NEXT, $urandom);
  endtask

  task automatic test_null_requests();
    send_request(CMD_ALLOC, '0, 32'hFFFF_FFFF);
    send_request(CMD_FREE, 32'hFFFF_FFFF, '0);
    send_request(CMD_FREE, '0, 32'h1234_5000);
  endtask

  // Page rounding, first-fit reuse and frees on a small frame budget
  task automatic test_first_fit_reuse();
    send_request(CMD_ALLOC, 32'd1, '0);
    send_request(CMD_ALLOC, 32'h0000_1001, '0);
    send_request(CMD_ALLOC, 32'h0000_2000, '0);
    send_request(CMD_FREE, '0, 32'h0000_2000);
    send_request(CMD_ALLOC, 32'h0000_0FFF, '0);
    send_request(CMD_FREE, '0, 32'h0000_3000);
    send_request(CMD_ALLOC, 32'h0000_1000, '0);
    send_request(CMD_FREE, '0, 32'h0000_4000);
  endtask

  task automatic test_out_of_memory();
    send_request(CMD_ALLOC, 32'h0000_4001, '0);
    send_request(CMD_ALLOC, 32'hFFFF_FFFF, '0);
    settle();
    write_register(REG_FREE_FRAMES, 32'd0);
    send_request(CMD_ALLOC, 32'd1, '0);
  endtask

  // Bump pointer rounding past the top, then regions ending one page short of it and at it
  task automatic test_address_overflow();
    begin_phase(32'hFFFF_FFFF, FRAMES_ALL);
    send_request(CMD_ALLOC, 32'd1, '0);
    settle();
    write_register(REG_HEAP_START, 32'hFFFF_E000);
    send_request(CMD_ALLOC, 32'h0000_1000, '0);
    send_request(CMD_ALLOC, 32'h0000_0FFF, '0);
  endtask

  task automatic test_zero_base();
    settle();
    write_register(REG_HEAP_START, '0);
    send_request(CMD_ALLOC, 32'h0000_0010, '0);
    send_request(CMD_FREE, '0, '0);
  endtask

  // Two overlapping large regions: free past the counter ceiling, then a
  // small request reusing one of them drives the count to zero
  task automatic test_frame_saturation();
    begin_phase(32'h1000_0000, FRAMES_ALL);
    send_request(CMD_ALLOC, 32'hC000_0000, '0);
    begin_phase(32'h1000_0000, FRAMES_ALL);
    send_request(CMD_ALLOC, 32'hC000_0000, '0);
    settle();
    write_register(REG_FREE_FRAMES, FRAMES_ALL);
    send_request(CMD_FREE, '0, 32'h1000_0000);
    send_request(CMD_FREE, '0, 32'h1000_0000);
    settle();
    write_register(REG_FREE_FRAMES, 32'd1);
    send_request(CMD_ALLOC, 32'h0000_1000, '0);
  endtask

  task automatic test_table_fill();
    begin_phase(32'h0040_0000, FRAMES_ALL);
    run_random_phase(400, 80);
  endtask

  task automatic test_mixed_traffic();
    begin_phase($urandom >> 4, $urandom_range(0, 1048576));
    run_random_phase(300, 45);
    begin_phase($urandom, FRAMES_ALL);
    run_random_phase(335, 45);
  endtask

  task automatic test_no_frames();
    begin_phase('0, '0);
    run_random_phase(150, 45);
  endtask

  task automatic test_heap_top();
    begin_phase(32'hFFFF_FFFF, FRAMES_ALL);
    run_random_phase(200, 50);
  endtask

  // Result side held off while requests keep coming
  task automatic test_output_backpressure();
    begin_phase($urandom >> 8, FRAMES_ALL);
    hold_cycles = LONG_HOLD;
    run_random_phase(15, 45);
  endtask

  task automatic test_quiet_stream();
    begin_phase($urandom >> 6, $urandom_range(0, 1048576));
    idle_on = 1'b0;
    run_random_phase(300, 45);
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tuser     = CMD_ALLOC;
    s_tdata     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_HEAP_START;
    cfg_data    = '0;
    idle_on     = 1'b1;
    hold_cycles = 0;
    mismatches  = 0;
    ent_fill    = 0;
    bump_addr   = '0;
    frames_left = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_register_writes();
    test_null_requests();
    test_first_fit_reuse();
    test_out_of_memory();
    test_address_overflow();
    test_zero_base();
    test_frame_saturation();
    test_table_fill();
    test_mixed_traffic();
    test_no_frames();
    test_heap_top();
    test_output_backpressure();
    test_quiet_stream();

    settle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
